// ===== design/svm_pkg.sv =====
package svm_pkg;

   localparam int StackDepth = 64;
   localparam int CountW = $clog2(StackDepth + 1);
   localparam logic [32:0] MemoryBytes = 33'd1048576;

   localparam logic [4:0] OP_NOP   = 5'd0;
   localparam logic [4:0] OP_LOAD  = 5'd1;
   localparam logic [4:0] OP_STORE = 5'd2;
   localparam logic [4:0] OP_ADD   = 5'd3;
   localparam logic [4:0] OP_SUB   = 5'd4;
   localparam logic [4:0] OP_MUL   = 5'd5;
   localparam logic [4:0] OP_CALL  = 5'd6;
   localparam logic [4:0] OP_RET   = 5'd7;
   localparam logic [4:0] OP_JMP   = 5'd8;
   localparam logic [4:0] OP_PUSH  = 5'd9;
   localparam logic [4:0] OP_POP   = 5'd10;
   localparam logic [4:0] OP_CKPT  = 5'd11;
   localparam logic [4:0] OP_FEXIT = 5'd12;
   localparam logic [4:0] OP_LEARN = 5'd13;
   localparam logic [4:0] OP_HEAL  = 5'd14;
   localparam logic [4:0] OP_OVL   = 5'd15;

   localparam logic [2:0] ST_DONE      = 3'd0;
   localparam logic [2:0] ST_RECOVERED = 3'd1;
   localparam logic [2:0] ST_FAULT     = 3'd2;
   localparam logic [2:0] ST_RANGE     = 3'd3;
   localparam logic [2:0] ST_END       = 3'd4;
   localparam logic [2:0] ST_IGNORED   = 3'd5;

   localparam logic [2:0] CSR_LENGTH = 3'd0;
   localparam logic [2:0] CSR_HEAL   = 3'd1;
   localparam logic [2:0] CSR_RANGE  = 3'd2;
   localparam logic [2:0] CSR_FIRST  = 3'd3;
   localparam logic [2:0] CSR_LAST   = 3'd4;

   // per-cycle stack command broadcast to every cell
   typedef struct packed {
      logic        enable;   // an item commits this cycle
      logic        push;     // shift down, new word enters at the top
      logic        pop;      // shift up
      logic        replace;  // after pop, the new top takes new_word
      logic        save;     // copy live row into checkpoint row
      logic        restore;  // copy checkpoint row into live row
      logic [31:0] new_word;
   } cell_cmd_type;

endpackage

// ===== design/svm_cell.sv =====
// One stack slot with its checkpoint copy. Cell 0 is the top of stack.
module svm_cell (
   input  logic                 clock,
   input  svm_pkg::cell_cmd_type cmd,
   input  logic [31:0]          above_word,
   input  logic [31:0]          below_word,
   input  logic                 is_top,
   output logic [31:0]          word,
   output logic [31:0]          saved_word
);

   logic [31:0] word_ff, word_in;
   logic [31:0] saved_ff, saved_in;

   // pick the next live value from neighbor, command or checkpoint
   always_comb begin
      word_in = word_ff;
      if (cmd.enable) begin
         if (cmd.restore) begin
            word_in = saved_ff;
         end else if (cmd.push) begin
            word_in = is_top ? cmd.new_word : above_word;
         end else if (cmd.pop) begin
            word_in = (is_top && cmd.replace) ? cmd.new_word : below_word;
         end
      end
      saved_in = (cmd.enable && cmd.save) ? word_ff : saved_ff;
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      saved_ff <= saved_in;
   end

   assign word       = word_ff;
   assign saved_word = saved_ff;

endmodule

// ===== design/svm_stack.sv =====
// Row of cells; the top two words feed the execute logic.
module svm_stack (
   input  logic                 clock,
   input  svm_pkg::cell_cmd_type cmd,
   output logic [31:0]          top_word,
   output logic [31:0]          next_word,
   output logic [31:0]          saved_top
);

   localparam int N = svm_pkg::StackDepth;

   logic [31:0] words [N];
   logic [31:0] saved [N];

   for (genvar i = 0; i < N; i++) begin : g_cell
      svm_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .above_word ((i == 0) ? cmd.new_word : words[(i == 0) ? 0 : i - 1]),
         .below_word ((i == N - 1) ? words[N - 1] : words[(i == N - 1) ? N - 1 : i + 1]),
         .is_top     (i == 0),
         .word       (words[i]),
         .saved_word (saved[i])
      );
   end

   assign top_word  = words[0];
   assign next_word = words[1];
   assign saved_top = saved[0];

endmodule

// ===== design/stack_vm_execute_unit_top.sv =====
// Stack-machine execute unit.
// The result of each accepted instruction is written into the output register.
// Throughput: one instruction per cycle while the output is not stalled; the stack
// is a row of shifting cells, so every push, pop and checkpoint copy is done in parallel.
// Reset (synchronous, active high): pc, counts, checkpoint flag and halt clear;
// configuration returns to its defaults; stack words are undefined until written.
module stack_vm_execute_unit_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,   // mode[4:0], immediate[36:5], zero fill
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata    // status[2:0], next_pc[34:3], write_valid[35],
                                     // write_address[55:36], write_word[87:56],
                                     // top_value[119:88], depth_now[126:120]
);

   localparam int CW = svm_pkg::CountW;
   localparam logic [CW-1:0] FullCount = CW'(svm_pkg::StackDepth);

   logic [31:0] length_ff, first_ff, last_ff;
   logic        heal_ff, range_ff;

   logic [31:0]   pc_ff, pc_in, saved_pc_ff;
   logic [CW-1:0] count_ff, count_in, saved_count_ff;
   logic          saved_valid_ff, halted_ff, halted_in;

   logic          rsp_valid_ff;
   logic [127:0]  rsp_data_ff, rsp_data_in;

   svm_pkg::cell_cmd_type cmd;
   logic [31:0] top_word, next_word, saved_top;

   logic [4:0]  mode;
   logic [31:0] imm;
   logic        fire;

   assign mode = req_tdata[4:0];
   assign imm  = req_tdata[36:5];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign fire = req_tvalid && req_tready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         heal_ff   <= 1'b1;
         range_ff  <= 1'b0;
         first_ff  <= '0;
         last_ff   <= '1;
      end else if (csr_write) begin
         case (csr_index)
            svm_pkg::CSR_LENGTH: length_ff <= csr_data;
            svm_pkg::CSR_HEAL:   heal_ff   <= csr_data[0];
            svm_pkg::CSR_RANGE:  range_ff  <= csr_data[0];
            svm_pkg::CSR_FIRST:  first_ff  <= csr_data;
            svm_pkg::CSR_LAST:   last_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   svm_stack u_stack (
      .clock     (clock),
      .cmd       (cmd),
      .top_word  (top_word),
      .next_word (next_word),
      .saved_top (saved_top)
   );

   // execute one instruction
   always_comb begin
      logic [32:0]   after_op, after_imm;
      logic          imm_ok, fault, wv, do_restore, end_hit, range_hit;
      logic [31:0]   npc, result, top_out;
      logic [2:0]    status;
      logic [CW-1:0] ncount;
      logic          empty, lt2, full;

      after_op  = {1'b0, pc_ff} + 33'd1;
      after_imm = after_op + 33'd4;
      imm_ok    = after_imm <= {1'b0, length_ff};
      npc       = after_op[31:0];
      ncount    = count_ff;
      empty     = count_ff == '0;
      lt2       = count_ff < CW'(2);
      full      = count_ff >= FullCount;
      fault = 1'b0; wv = 1'b0; do_restore = 1'b0;
      result = '0;
      cmd = '0;

      case (mode)
         svm_pkg::OP_NOP, svm_pkg::OP_FEXIT, svm_pkg::OP_LEARN, svm_pkg::OP_OVL: ;
         svm_pkg::OP_LOAD: begin
            if (!imm_ok || full) fault = 1'b1;
            else begin
               cmd.push = 1'b1; cmd.new_word = imm;
               ncount = count_ff + CW'(1); npc = after_imm[31:0];
            end
         end
         svm_pkg::OP_STORE: begin
            if (empty || !imm_ok || ({1'b0, imm} + 33'd4 > svm_pkg::MemoryBytes)) fault = 1'b1;
            else begin
               cmd.pop = 1'b1; wv = 1'b1;
               ncount = count_ff - CW'(1); npc = after_imm[31:0];
            end
         end
         svm_pkg::OP_ADD, svm_pkg::OP_SUB, svm_pkg::OP_MUL: begin
            if (lt2) fault = 1'b1;
            else begin
               if (mode == svm_pkg::OP_ADD) result = next_word + top_word;
               else if (mode == svm_pkg::OP_SUB) result = next_word - top_word;
               else result = next_word * top_word;
               cmd.pop = 1'b1; cmd.replace = 1'b1; cmd.new_word = result;
               ncount = count_ff - CW'(1);
            end
         end
         svm_pkg::OP_CALL: begin
            if (!imm_ok || full) fault = 1'b1;
            else begin
               cmd.push = 1'b1; cmd.new_word = after_imm[31:0];
               ncount = count_ff + CW'(1); npc = imm;
            end
         end
         svm_pkg::OP_RET: begin
            if (empty) fault = 1'b1;
            else begin
               cmd.pop = 1'b1; ncount = count_ff - CW'(1); npc = top_word;
            end
         end
         svm_pkg::OP_JMP: begin
            if (!imm_ok) fault = 1'b1;
            else npc = imm;
         end
         svm_pkg::OP_PUSH: fault = empty;
         svm_pkg::OP_POP: begin
            if (empty) fault = 1'b1;
            else begin
               cmd.pop = 1'b1; ncount = count_ff - CW'(1);
            end
         end
         svm_pkg::OP_CKPT: begin
            cmd.save = 1'b1;
         end
         svm_pkg::OP_HEAL: begin
            if (saved_valid_ff) begin
               do_restore = 1'b1; npc = saved_pc_ff; ncount = saved_count_ff;
            end
         end
         default: fault = 1'b1;
      endcase

      if (fault) begin
         cmd = '0;
         wv = 1'b0;
         if (heal_ff && saved_valid_ff) begin
            do_restore = 1'b1; npc = saved_pc_ff; ncount = saved_count_ff;
         end else begin
            npc = pc_ff; ncount = count_ff;
         end
      end
      cmd.restore = do_restore;

      range_hit = range_ff && ((npc < first_ff) || (npc > last_ff));
      end_hit   = npc >= length_ff;
      pc_in = pc_ff; count_in = count_ff; halted_in = halted_ff;

      if (halted_ff) begin
         status = svm_pkg::ST_IGNORED; cmd = '0; wv = 1'b0;
      end else if (pc_ff >= length_ff) begin
         status = svm_pkg::ST_END; cmd = '0; wv = 1'b0; halted_in = 1'b1;
      end else if (fault) begin
         pc_in = npc; count_in = ncount;
         if (do_restore) status = svm_pkg::ST_RECOVERED;
         else begin
            status = svm_pkg::ST_FAULT; halted_in = 1'b1;
         end
      end else begin
         pc_in = npc; count_in = ncount;
         if (range_hit) begin
            status = svm_pkg::ST_RANGE; halted_in = 1'b1;
         end else if (end_hit) begin
            status = svm_pkg::ST_END; halted_in = 1'b1;
         end else status = svm_pkg::ST_DONE;
      end
      cmd.enable = fire;

      // top of stack as it will stand after the step
      if (count_in == '0) top_out = '0;
      else if (cmd.restore) top_out = saved_top;
      else if (cmd.push) top_out = cmd.new_word;
      else if (cmd.pop && cmd.replace) top_out = cmd.new_word;
      else if (cmd.pop) top_out = next_word;
      else top_out = top_word;

      rsp_data_in = '0;
      rsp_data_in[2:0]     = status;
      rsp_data_in[34:3]    = pc_in;
      rsp_data_in[35]      = wv;
      rsp_data_in[55:36]   = wv ? imm[19:0] : 20'd0;
      rsp_data_in[87:56]   = wv ? top_word : 32'd0;
      rsp_data_in[119:88]  = top_out;
      rsp_data_in[126:120] = 7'(count_in);
   end

   // architectural state and checkpoint
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff          <= '0;
         count_ff       <= '0;
         saved_pc_ff    <= '0;
         saved_count_ff <= '0;
         saved_valid_ff <= 1'b0;
         halted_ff      <= 1'b0;
      end else if (fire) begin
         pc_ff     <= pc_in;
         count_ff  <= count_in;
         halted_ff <= halted_in;
         if (cmd.save) begin
            saved_pc_ff    <= pc_ff + 32'd1;
            saved_count_ff <= count_ff;
            saved_valid_ff <= 1'b1;
         end
      end
   end

   // output register: hold until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (fire) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (fire) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
